// ===== rtl/csmv_pkg.sv =====
// Shared types, constants and helpers for the sparse matrix-vector product block.
// Used by csmv_front, csmv_back and the top module; depends on nothing else.
`timescale 1ns / 1ps

package csmv_pkg;

    localparam int VEC_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int RESULT_DEPTH  = 4;

    localparam int COL_W      = 8;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int VLEN_W     = 9;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [VLEN_W-1:0]     VLEN_RESET        = 9'd256;
    localparam logic [APB_ADDR_W-1:0] REG_VECTOR_LENGTH = 2'd0;

    localparam logic signed [ACC_W-1:0]  ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [ACC_W-1:0]  ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [DATA_W-1:0] SUM_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SUM_MIN = 32'sh8000_0000;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_NONZERO = 2'd1;
    localparam logic [1:0] CMD_CLOSE   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MAC   = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [COL_W-1:0]          col;
        logic signed [DATA_W-1:0]  value;
        logic                      row_end;
    } work_t;

    typedef struct packed {
        logic [COL_W-1:0]          row_number;
        logic signed [DATA_W-1:0]  row_sum;
        logic                      last_row;
        logic                      saturated;
    } result_t;

    function automatic int csmv_mem_depth(input int vec_depth);
        return (vec_depth < 256) ? vec_depth : 256;
    endfunction

endpackage

// ===== rtl/csmv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instanced for the dense vector store.
`timescale 1ns / 1ps

module csmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csmv_fifo.sv =====
// Small synchronous FIFO used for the work queue and the result queue.
// Depends on nothing; depth and word width come from parameters.
`timescale 1ns / 1ps

module csmv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("FIFO count exceeds its depth.");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("FIFO count did not rise after a lone push.");

    a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("FIFO count did not fall after a lone pop.");

endmodule

// ===== rtl/csmv_front.sv =====
// Front end: configuration register, input word classification and work queue.
// Depends on csmv_pkg and csmv_fifo.
`timescale 1ns / 1ps

module csmv_front
    import csmv_pkg::*;
#(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               command,
    input  logic [COL_W-1:0]         column_index,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     row_end,
    output logic [VLEN_W-1:0]        n_eff,
    output work_t                    head,
    output logic                     head_empty,
    input  logic                     head_pop
);

    localparam int MEM_DEPTH = csmv_mem_depth(VEC_DEPTH);
    localparam logic [VLEN_W-1:0] N_LIMIT   = VLEN_W'(MEM_DEPTH);
    localparam logic [16:0]       LOAD_LIMIT = 17'(VEC_DEPTH);

    logic [VLEN_W-1:0]         vlen_reg, vlen_next;
    logic                      cfg_write;
    logic                      accept;
    logic                      keep;
    work_t                     item;
    logic [$bits(work_t)-1:0]  head_bits;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_VECTOR_LENGTH);
    assign prdata    = (paddr == REG_VECTOR_LENGTH) ?
                       {{(APB_DATA_W - VLEN_W){1'b0}}, vlen_reg} : '0;

    always_comb
    begin
        vlen_next = cfg_write ? pwdata[VLEN_W-1:0] : vlen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= VLEN_RESET;
        end
        else
        begin
            vlen_reg <= vlen_next;
        end
    end

    always_comb
    begin
        if (vlen_reg == '0)
        begin
            n_eff = VLEN_W'(1);
        end
        else if (vlen_reg > N_LIMIT)
        begin
            n_eff = N_LIMIT;
        end
        else
        begin
            n_eff = vlen_reg;
        end
    end

    // A nonzero outside the active columns adds nothing, so only its row end survives.
    always_comb
    begin
        keep         = 1'b0;
        item.op      = OP_CLOSE;
        item.col     = column_index;
        item.value   = element_value;
        item.row_end = row_end;
        unique case (command)
            CMD_LOAD:
            begin
                item.op = OP_LOAD;
                keep    = ({9'b0, column_index} < LOAD_LIMIT);
            end
            CMD_NONZERO:
            begin
                if ({1'b0, column_index} < n_eff)
                begin
                    item.op = OP_MAC;
                    keep    = 1'b1;
                end
                else
                begin
                    item.op = OP_CLOSE;
                    keep    = row_end;
                end
            end
            CMD_CLOSE:
            begin
                item.op = OP_CLOSE;
                keep    = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign accept = push && !full;

    csmv_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept && keep),
        .din   (item),
        .full  (full),
        .pop   (head_pop),
        .dout  (head_bits),
        .empty (head_empty)
    );

    assign head = work_t'(head_bits);

endmodule

// ===== rtl/csmv_back.sv =====
// Back end: vector store, multiply, saturating accumulate and row result formation.
// Depends on csmv_pkg and csmv_ram.
`timescale 1ns / 1ps

module csmv_back
    import csmv_pkg::*;
#(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  work_t             head,
    input  logic              head_empty,
    output logic              head_pop,
    input  logic [VLEN_W-1:0] n_eff,
    output result_t           res,
    output logic              res_valid,
    input  logic              res_ready
);

    localparam int MEM_DEPTH = csmv_mem_depth(VEC_DEPTH);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic                      adv;
    logic                      ram_we, ram_re;
    logic signed [DATA_W-1:0]  ram_rdata;

    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_close_reg;
    logic                      s1_zero_reg;
    logic signed [DATA_W-1:0]  s1_val_reg;
    logic signed [ACC_W-1:0]   product;

    logic                      p_valid_reg, p_close_reg;
    logic signed [ACC_W-1:0]   p_reg, p_next;

    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W:0]            sum_wide;
    logic signed [ACC_W-1:0]   sat_sum;

    logic                      s3_valid_reg, s3_valid_next;
    logic signed [ACC_W-1:0]   s3_sum_reg;
    logic signed [ACC_W-1:0]   scaled;
    logic [ACC_W-DATA_W:0]     scaled_hi;
    logic                      clip;

    logic [COL_W-1:0]          row_reg, row_next;
    logic [VLEN_W-1:0]         row_inc;

    assign adv      = !(s3_valid_reg && !res_ready);
    assign head_pop = adv && !head_empty;
    assign ram_we   = head_pop && (head.op == OP_LOAD);
    assign ram_re   = head_pop && (head.op == OP_MAC);

    csmv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_vector_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.col[ADDR_W-1:0]),
        .wdata (head.value),
        .re    (ram_re),
        .raddr (head.col[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s1_valid_next = head_pop && (head.op != OP_LOAD);
    assign product       = s1_val_reg * ram_rdata;
    assign p_next        = s1_zero_reg ? '0 : product;

    always_comb
    begin
        sum_wide = {acc_reg[ACC_W-1], acc_reg} + {p_reg[ACC_W-1], p_reg};
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sat_sum = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sat_sum = sum_wide[ACC_W-1:0];
        end
        acc_next      = acc_reg;
        s3_valid_next = s3_valid_reg;
        if (adv)
        begin
            s3_valid_next = p_valid_reg && p_close_reg;
            if (p_valid_reg)
            begin
                acc_next = p_close_reg ? '0 : sat_sum;
            end
        end
    end

    always_comb
    begin
        scaled    = s3_sum_reg >>> FRAC_BITS;
        scaled_hi = scaled[ACC_W-1:DATA_W-1];
        clip      = !((&scaled_hi) || !(|scaled_hi));
        row_inc   = {1'b0, row_reg} + 1'b1;
        row_next  = row_reg;
        if (s3_valid_reg && res_ready)
        begin
            row_next = (row_inc >= n_eff) ? '0 : row_inc[COL_W-1:0];
        end
    end

    assign res_valid      = s3_valid_reg;
    assign res.row_number = row_reg;
    assign res.row_sum    = clip ? (scaled[ACC_W-1] ? SUM_MIN : SUM_MAX)
                                 : scaled[DATA_W-1:0];
    assign res.last_row   = ({1'b0, row_reg} == n_eff - 1'b1);
    assign res.saturated  = clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            s3_valid_reg <= 1'b0;
            acc_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= s1_valid_next;
                p_valid_reg  <= s1_valid_reg;
            end
            s3_valid_reg <= s3_valid_next;
            acc_reg      <= acc_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_close_reg <= (head.op == OP_CLOSE) || head.row_end;
            s1_zero_reg  <= (head.op == OP_CLOSE);
            s1_val_reg   <= head.value;
            p_close_reg  <= s1_close_reg;
            p_reg        <= p_next;
            s3_sum_reg   <= sat_sum;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !res_ready |=>
            s3_valid_reg && $stable(s3_sum_reg) && $stable(row_reg))
        else $error("Stalled row result changed before it was taken.");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        adv && p_valid_reg && p_close_reg |=> acc_reg == '0)
        else $error("Accumulator not cleared after a row closed.");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.saturated |-> (res.row_sum == SUM_MAX || res.row_sum == SUM_MIN))
        else $error("Saturated row sum is not at a range limit.");

endmodule

// ===== rtl/csr_sparse_matrix_vector_product.sv =====
// Sparse matrix times dense vector, compressed-row streaming form.
// Input words go in through a push/full queue port. Command 0 loads one
// element of the dense vector, command 1 is a matrix nonzero (column and
// value, row_end on the last one of its row), command 2 closes an empty row.
// Each closed row yields one result word on an empty/pop queue port: row
// number, Q16.16 row sum clipped to range, a last-row flag and a clip flag.
// vector_length sits at APB byte address 0; the user must write it only while
// idle, which the block does not enforce. One input word is taken per cycle
// while full is low. A result reaches the output ports once the word closing its
// row has passed the work queue, vector store read, multiply, saturating accumulate
// and then the result queue. The vector store is a single-write, single-read RAM
// with a registered read port, read as the work queue hands over the word.
// Reset empties both queues, clears the accumulator and the row counter and
// sets vector_length to 256; vector store contents stay undefined until loaded.
// When pop stays low the result queue fills, the back end stops and the work
// queue fills behind it; full then rises and nothing is lost.
// Depends on csmv_pkg, csmv_front, csmv_back and csmv_fifo.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_product
    import csmv_pkg::*;
#(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               command,
    input  logic [COL_W-1:0]         column_index,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     row_end,
    output logic                     empty,
    input  logic                     pop,
    output logic [COL_W-1:0]         row_number,
    output logic signed [DATA_W-1:0] row_sum,
    output logic                     last_row,
    output logic                     saturated
);

    logic [VLEN_W-1:0]          n_eff;
    work_t                      head;
    logic                       head_empty;
    logic                       head_pop;
    result_t                    res;
    logic                       res_valid;
    logic                       res_full;
    logic [$bits(result_t)-1:0] out_bits;
    result_t                    out_word;

    csmv_front #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .command       (command),
        .column_index  (column_index),
        .element_value (element_value),
        .row_end       (row_end),
        .n_eff         (n_eff),
        .head          (head),
        .head_empty    (head_empty),
        .head_pop      (head_pop)
    );

    csmv_back #(
        .VEC_DEPTH (VEC_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .n_eff      (n_eff),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (!res_full)
    );

    csmv_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_bits),
        .empty (empty)
    );

    assign out_word   = result_t'(out_bits);
    assign row_number = out_word.row_number;
    assign row_sum    = out_word.row_sum;
    assign last_row   = out_word.last_row;
    assign saturated  = out_word.saturated;

endmodule
